@@ design/icmp_pkg.sv @@
// Shared types, codes and helpers for the ICMP echo responder.
package icmp_pkg;

	localparam int PENDING_DEPTH_DEF = 8;
	localparam int MAX_PAYLOAD_DEF   = 56;
	localparam int HDR_LEN           = 8;
	localparam int LEN_W             = 6;
	localparam int POS_W             = 7;
	localparam logic [7:0] TYPE_ECHO_REQ = 8'd8;

	typedef enum logic [1:0] {
		KIND_VERDICT = 2'd0,
		KIND_REPLY   = 2'd1,
		KIND_EMPTY   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		VD_ACCEPT    = 3'd0,
		VD_SHORT     = 3'd1,
		VD_BAD_CSUM  = 3'd2,
		VD_NOT_ECHO  = 3'd3,
		VD_TOO_LARGE = 3'd4
	} verdict_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HDR,
		ST_STREAM,
		ST_COPY
	} state_t;

	// receive-side result, valid in the cycle of the final byte
	typedef struct packed {
		verdict_t         verdict;
		logic [LEN_W-1:0] plen;
		logic [15:0]      ident;
		logic [15:0]      seq;
		logic [15:0]      csum;
	} rx_res_t;

	typedef struct packed {
		logic [31:0]      sender;
		logic [15:0]      ident;
		logic [15:0]      seq;
		logic [15:0]      csum;
		logic [LEN_W-1:0] plen;
	} hdr_entry_t;

	function automatic logic [15:0] fold_add(input logic [15:0] s, input logic [15:0] w);
		logic [16:0] t;
		t = {1'b0, s} + {1'b0, w};
		return t[15:0] + {15'd0, t[16]};
	endfunction

endpackage

@@ design/icmp_echo_responder.sv @@
// ICMP echo responder: checks incoming echo requests, queues them, streams echo replies.
// Message bytes (op 0) are taken one per cycle when ready; the final byte yields a verdict
// in the following cycle. An accepted, stored request with N payload bytes then holds off
// input while its payload is copied from the staging area of the payload RAM into its queue
// slot (one RAM read and one write per cycle). A reply request (op 1) on an empty queue
// answers at once; otherwise the header is read from the header RAM and the reply streams
// 8 + N bytes, one per cycle while the output is free: header bytes from the stored header,
// payload bytes from the payload RAM's read port, reply checksum precomputed at receive time.
// Input is taken again after the last reply byte has been loaded into the output register.
module icmp_echo_responder import icmp_pkg::*; #(
	parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
	parameter int MAX_PAYLOAD   = MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic [31:0] src_ip,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [2:0]  verdict,
	output logic        queued,
	output logic [7:0]  reply_byte,
	output logic        reply_last,
	output logic [31:0] dst_ip,
	output logic [31:0] accepted_count,
	output logic [31:0] rejected_count
);

	localparam int SLOT_W    = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int HELD_W    = $clog2(PENDING_DEPTH + 1);
	localparam int PAY_TOTAL = (PENDING_DEPTH + 1) * MAX_PAYLOAD;
	localparam int PAY_DEPTH = (PAY_TOTAL > 1) ? PAY_TOTAL : 2;
	localparam int PAY_AW    = $clog2(PAY_DEPTH);
	localparam int STG_BASE  = PENDING_DEPTH * MAX_PAYLOAD;
	localparam int HDR_W     = $bits(hdr_entry_t);

	state_t state_q, state_d;

	logic              out_valid_q, queued_q, rlast_q;
	kind_t             kind_q;
	verdict_t          verdict_q;
	logic [7:0]        rbyte_q;
	logic [31:0]       dst_q, acc_q, rej_q;
	logic [SLOT_W-1:0] rd_slot_q, wr_slot_q;
	logic [HELD_W-1:0] held_q;
	logic [POS_W-1:0]  pos_q, pos_d, total;
	hdr_entry_t        hdr_q, hdr_rd, hdr_wr;
	logic [LEN_W-1:0]  cp_q, cp_len_q;
	logic [PAY_AW-1:0] cp_base_q, rd_base, wr_base;

	rx_res_t           rx_res;
	logic              rx_stg_we;
	logic [LEN_W-1:0]  rx_stg_idx;

	logic              take, out_free, full, do_commit, do_verdict, pop_done, cp_start;
	logic              out_load, o_queued, o_last;
	kind_t             o_kind;
	verdict_t          o_verdict;
	logic [7:0]        o_byte, stream_byte;
	logic [31:0]       o_dst;

	logic              pay_we;
	logic [PAY_AW-1:0] pay_waddr, pay_raddr;
	logic [7:0]        pay_wdata, pay_rdata;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign take     = in_valid && in_ready;
	assign full     = (held_q == HELD_W'(PENDING_DEPTH));
	assign do_verdict = take && !op && last_byte;
	assign do_commit  = do_verdict && (rx_res.verdict == VD_ACCEPT) && !full;
	assign cp_start   = do_commit && (rx_res.plen != '0);
	assign rd_base    = PAY_AW'(rd_slot_q) * PAY_AW'(MAX_PAYLOAD);
	assign wr_base    = PAY_AW'(wr_slot_q) * PAY_AW'(MAX_PAYLOAD);
	assign total      = POS_W'(HDR_LEN) + POS_W'(hdr_q.plen);

	icmp_rx #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_rx (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take && !op),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.res       (rx_res),
		.stg_we    (rx_stg_we),
		.stg_idx   (rx_stg_idx)
	);

	assign hdr_wr = '{sender: src_ip, ident: rx_res.ident, seq: rx_res.seq,
	                  csum: rx_res.csum, plen: rx_res.plen};

	icmp_ram #(.WIDTH(HDR_W), .DEPTH(PENDING_DEPTH)) u_hdr_ram (
		.clk   (clk),
		.we    (do_commit),
		.waddr (wr_slot_q),
		.wdata (hdr_wr),
		.raddr (rd_slot_q),
		.rdata (hdr_rd)
	);

	icmp_ram #(.WIDTH(8), .DEPTH(PAY_DEPTH)) u_pay_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr (pay_waddr),
		.wdata (pay_wdata),
		.raddr (pay_raddr),
		.rdata (pay_rdata)
	);

	always_comb begin
		stream_byte = pay_rdata;
		if (pos_q < POS_W'(HDR_LEN)) begin
			case (pos_q[2:0])
				3'd2:    stream_byte = hdr_q.csum[15:8];
				3'd3:    stream_byte = hdr_q.csum[7:0];
				3'd4:    stream_byte = hdr_q.ident[15:8];
				3'd5:    stream_byte = hdr_q.ident[7:0];
				3'd6:    stream_byte = hdr_q.seq[15:8];
				3'd7:    stream_byte = hdr_q.seq[7:0];
				default: stream_byte = 8'h00;
			endcase
		end
	end

	always_comb begin
		state_d   = state_q;
		out_load  = 1'b0;
		o_kind    = KIND_VERDICT;
		o_verdict = VD_ACCEPT;
		o_queued  = 1'b0;
		o_byte    = 8'h00;
		o_last    = 1'b0;
		o_dst     = 32'd0;
		pos_d     = pos_q;
		pop_done  = 1'b0;
		pay_we    = rx_stg_we;
		pay_waddr = PAY_AW'(STG_BASE) + PAY_AW'(rx_stg_idx);
		pay_wdata = data_byte;
		unique case (state_q)
			ST_IDLE: begin
				if (do_verdict) begin
					out_load  = 1'b1;
					o_verdict = rx_res.verdict;
					o_queued  = do_commit;
					if (cp_start)
						state_d = ST_COPY;
				end else if (take && op) begin
					if (held_q == '0) begin
						out_load = 1'b1;
						o_kind   = KIND_EMPTY;
					end else begin
						state_d = ST_HDR;
					end
				end
			end
			ST_HDR: begin
				pos_d   = '0;
				state_d = ST_STREAM;
			end
			ST_STREAM: begin
				if (out_free) begin
					out_load = 1'b1;
					o_kind   = KIND_REPLY;
					o_byte   = stream_byte;
					o_dst    = hdr_q.sender;
					o_last   = (pos_q == total - POS_W'(1));
					pos_d    = pos_q + POS_W'(1);
					if (o_last) begin
						pop_done = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			ST_COPY: begin
				// read staging at cp_q, write the byte read last cycle
				pay_we    = (cp_q != '0);
				pay_waddr = cp_base_q + PAY_AW'(cp_q - LEN_W'(1));
				pay_wdata = pay_rdata;
				if (cp_q == cp_len_q)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		// reply reads run one position ahead so data lines up with pos_q
		if (state_q == ST_COPY)
			pay_raddr = PAY_AW'(STG_BASE) + PAY_AW'(cp_q);
		else
			pay_raddr = rd_base + PAY_AW'(pos_d - POS_W'(HDR_LEN));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rd_slot_q   <= '0;
			wr_slot_q   <= '0;
			held_q      <= '0;
			acc_q       <= '0;
			rej_q       <= '0;
			pos_q       <= '0;
			cp_q        <= '0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (do_verdict) begin
				if (rx_res.verdict == VD_ACCEPT)
					acc_q <= acc_q + 32'd1;
				else
					rej_q <= rej_q + 32'd1;
			end
			if (do_commit) begin
				wr_slot_q <= (wr_slot_q == SLOT_W'(PENDING_DEPTH - 1)) ? '0
				             : wr_slot_q + SLOT_W'(1);
				held_q    <= held_q + HELD_W'(1);
			end else if (pop_done) begin
				held_q    <= held_q - HELD_W'(1);
			end
			if (pop_done)
				rd_slot_q <= (rd_slot_q == SLOT_W'(PENDING_DEPTH - 1)) ? '0
				             : rd_slot_q + SLOT_W'(1);
			pos_q <= pos_d;
			if (cp_start)
				cp_q <= '0;
			else if (state_q == ST_COPY)
				cp_q <= cp_q + LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q    <= o_kind;
			verdict_q <= o_verdict;
			queued_q  <= o_queued;
			rbyte_q   <= o_byte;
			rlast_q   <= o_last;
			dst_q     <= o_dst;
		end
		if (state_q == ST_HDR)
			hdr_q <= hdr_rd;
		if (cp_start) begin
			cp_len_q  <= rx_res.plen;
			cp_base_q <= wr_base;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign verdict        = verdict_q;
	assign queued         = queued_q;
	assign reply_byte     = rbyte_q;
	assign reply_last     = rlast_q;
	assign dst_ip         = dst_q;
	assign accepted_count = acc_q;
	assign rejected_count = rej_q;

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HELD_W'(PENDING_DEPTH))
		else $error("queue occupancy above depth");

	a_last_is_reply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rlast_q |-> kind_q == KIND_REPLY)
		else $error("reply_last on a non-reply transaction");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		take && op && (held_q == '0) |=> out_valid_q && (kind_q == KIND_EMPTY))
		else $error("pop on empty queue did not report empty");

	a_copy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY) || (state_q == ST_STREAM) |-> !in_ready)
		else $error("input taken during payload copy or reply");

endmodule

@@ design/icmp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module icmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

@@ design/icmp_rx.sv @@
// Receive side: byte counter, running checksums, header capture and verdict.
module icmp_rx import icmp_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	output rx_res_t          res,
	output logic             stg_we,
	output logic [LEN_W-1:0] stg_idx
);

	logic [15:0] cnt_q, sum_q, sum2_q, ident_q, seq_q;
	logic [7:0]  hi_q, type_q;

	logic [15:0] word, fsum, fsum2, cnt_nx, ident_nx, seq_nx, off, plen16;
	logic [7:0]  type_nx;

	always_comb begin
		word   = cnt_q[0] ? {hi_q, data_byte} : {data_byte, 8'h00};
		fsum   = fold_add(sum_q, word);
		// reply checksum covers everything from the identifier on
		fsum2  = (cnt_q >= 16'd4) ? fold_add(sum2_q, word) : sum2_q;
		cnt_nx = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;
		type_nx  = (cnt_q == 16'd0) ? data_byte : type_q;
		ident_nx = ident_q;
		seq_nx   = seq_q;
		if (cnt_q == 16'd4) ident_nx[15:8] = data_byte;
		if (cnt_q == 16'd5) ident_nx[7:0]  = data_byte;
		if (cnt_q == 16'd6) seq_nx[15:8]   = data_byte;
		if (cnt_q == 16'd7) seq_nx[7:0]    = data_byte;
		off     = cnt_q - 16'(HDR_LEN);
		stg_we  = take && (cnt_q >= 16'(HDR_LEN)) && ({1'b0, off} < 17'(MAX_PAYLOAD));
		stg_idx = off[LEN_W-1:0];
		plen16  = cnt_nx - 16'(HDR_LEN);

		if (cnt_nx < 16'(HDR_LEN))
			res.verdict = VD_SHORT;
		else if (fsum != 16'hFFFF)
			res.verdict = VD_BAD_CSUM;
		else if (type_nx != TYPE_ECHO_REQ)
			res.verdict = VD_NOT_ECHO;
		else if ({1'b0, plen16} > 17'(MAX_PAYLOAD))
			res.verdict = VD_TOO_LARGE;
		else
			res.verdict = VD_ACCEPT;
		res.plen  = plen16[LEN_W-1:0];
		res.ident = ident_nx;
		res.seq   = seq_nx;
		res.csum  = 16'hFFFF - fsum2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			sum2_q  <= '0;
			hi_q    <= '0;
			type_q  <= '0;
			ident_q <= '0;
			seq_q   <= '0;
		end else if (take) begin
			if (last_byte) begin
				cnt_q   <= '0;
				sum_q   <= '0;
				sum2_q  <= '0;
				hi_q    <= '0;
				type_q  <= '0;
				ident_q <= '0;
				seq_q   <= '0;
			end else begin
				if (!cnt_q[0]) begin
					hi_q <= data_byte;
				end else begin
					sum_q  <= fsum;
					sum2_q <= fsum2;
				end
				cnt_q   <= cnt_nx;
				type_q  <= type_nx;
				ident_q <= ident_nx;
				seq_q   <= seq_nx;
			end
		end
	end

endmodule
